@@ design/pol_pkg.sv @@
package pol_pkg;

    // fixed field widths of the command and result beats
    localparam int CMD_W         = 3;
    localparam int KEY_W         = 16;
    localparam int POS_W         = 7;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 7;
    localparam int DEPTH_DEFAULT = 64;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_INS_POS  = 3'd2,
        CMD_REM_HEAD = 3'd3,
        CMD_REM_TAIL = 3'd4,
        CMD_REM_POS  = 3'd5
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // operation broadcast to the cell chain
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_REM  = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
    } cell_ctrl_t;

endpackage

@@ design/pol_req_if.sv @@
interface pol_req_if
    import pol_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    item_key;
    logic [POS_W-1:0]    position;

    modport source (output valid, cmd, item_key, position, input ready);
    modport sink   (input valid, cmd, item_key, position, output ready);
endinterface

@@ design/pol_rsp_if.sv @@
interface pol_rsp_if
    import pol_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    removed_key;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, removed_key, entry_count, input ready);
    modport sink   (input valid, status, removed_key, entry_count, output ready);
endinterface

@@ design/positional_ordered_list.sv @@
// channel  | dir | beat contents
// ---------+-----+-------------------------------------------
// req      | in  | cmd, item_key, position
// rsp      | out | status, removed_key, entry_count
//
// each command runs through decode, one shift of the cell chain, and collect
// of the removed key into the result register
// a new command is taken in the cycle after the collect, also while a result waits
// rst_n clears the entry count and the control; cell contents are not cleared
// a stalled rsp holds the chain in the collect step until the result slot frees
module positional_ordered_list
    import pol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    pol_req_if.sink       req,
    pol_rsp_if.source     rsp
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef logic [CMPW-1:0] cmp_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SHIFT,
        PH_COLLECT
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [CW-1:0]       count_reg, count_next;
    cell_ctrl_t          ctrl_reg, ctrl_next;
    logic [IW-1:0]       pos_reg, pos_next;
    status_t             pend_status_reg, pend_status_next;
    logic                pend_rem_reg, pend_rem_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic                accept;
    logic                load_out;
    cmp_t                cnt_ext;
    cmp_t                pos_ext;
    cmp_t                dec_pos;
    status_t             dec_status;
    op_t                 dec_op;
    logic [KEY_W-1:0]    taps_or;

    logic [KEY_W-1:0]    entry_w [DEPTH];
    logic [KEY_W-1:0]    tap_w   [DEPTH];

    assign accept   = req.valid && req.ready;
    assign load_out = (phase_reg == PH_COLLECT) && (!out_valid_reg || rsp.ready);
    assign cnt_ext  = cmp_t'(count_reg);
    assign pos_ext  = cmp_t'(req.position);

    // command decode against the current count
    always_comb
    begin
        dec_pos    = '0;
        dec_status = ST_OK;
        dec_op     = OP_NONE;
        case (req.cmd)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS:
            begin
                if (req.cmd == CMD_INS_TAIL)
                begin
                    dec_pos = cnt_ext;
                end
                else if (req.cmd == CMD_INS_POS)
                begin
                    dec_pos = pos_ext;
                end
                if (dec_pos > cnt_ext)
                begin
                    dec_status = ST_RANGE;
                end
                else if (count_reg == CW'(DEPTH))
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_op = OP_INS;
                end
            end
            CMD_REM_HEAD, CMD_REM_TAIL:
            begin
                if (count_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_op = OP_REM;
                    if (req.cmd == CMD_REM_TAIL)
                    begin
                        dec_pos = cnt_ext - 1'b1;
                    end
                end
            end
            CMD_REM_POS:
            begin
                dec_pos = pos_ext;
                if (pos_ext >= cnt_ext)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_op = OP_REM;
                end
            end
            default:
            begin
            end
        endcase
    end

    // gather the removed key from the chain
    always_comb
    begin
        taps_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            taps_or = taps_or | tap_w[i];
        end
    end

    // sequencer and result register
    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        ctrl_next        = ctrl_reg;
        pos_next         = pos_reg;
        pend_status_next = pend_status_reg;
        pend_rem_next    = pend_rem_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_key_next     = out_key_reg;
        out_count_next   = out_count_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                begin
                    ctrl_next.op     = dec_op;
                    ctrl_next.key    = req.item_key;
                    pos_next         = IW'(dec_pos);
                    pend_status_next = dec_status;
                    pend_rem_next    = (dec_op == OP_REM);
                    if (dec_op == OP_INS)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else if (dec_op == OP_REM)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    phase_next = PH_SHIFT;
                end
            end
            PH_SHIFT:
            begin
                ctrl_next.op = OP_NONE;
                phase_next   = PH_COLLECT;
            end
            PH_COLLECT:
            begin
                if (load_out)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_key_next    = pend_rem_reg ? taps_or : '0;
                    out_count_next  = COUNT_W'(count_reg);
                    phase_next      = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            count_reg       <= '0;
            ctrl_reg        <= '{op: OP_NONE, key: '0};
            pos_reg         <= '0;
            pend_status_reg <= ST_OK;
            pend_rem_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_OK;
            out_key_reg     <= '0;
            out_count_reg   <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            ctrl_reg        <= ctrl_next;
            pos_reg         <= pos_next;
            pend_status_reg <= pend_status_next;
            pend_rem_reg    <= pend_rem_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_key_reg     <= out_key_next;
            out_count_reg   <= out_count_next;
        end
    end

    // chain of cells, slot 0 is the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0] left_w;
        logic [KEY_W-1:0] right_w;

        if (i == 0)
        begin : g_head
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = entry_w[i+1];
        end

        pol_cell #(
            .IDX_W (IW),
            .INDEX (IW'(i))
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl_reg),
            .pos   (pos_reg),
            .left  (left_w),
            .right (right_w),
            .entry (entry_w[i]),
            .tap   (tap_w[i])
        );
    end

    // ports
    assign req.ready       = (phase_reg == PH_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.removed_key = out_key_reg;
    assign rsp.entry_count = out_count_reg;

`ifndef SYNTHESIS
    // the list never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // an accepted remove lowers the count by exactly one
    a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec_op == OP_REM) |=> (count_reg + 1'b1 == $past(count_reg)))
        else $error("remove did not lower the count by one");

    // the chain is driven for a single shift per command
    a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.op != OP_NONE) |=> (ctrl_reg.op == OP_NONE))
        else $error("chain shifted twice for one command");

    // a nonzero removed key only comes with an ok status
    a_key_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.removed_key != '0) |-> (rsp.status == ST_OK))
        else $error("removed key on a failed command");

    // a fresh result is only loaded from the collect step
    a_load_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !out_valid_reg) |-> (phase_reg == PH_COLLECT))
        else $error("result loaded outside the collect step");
`endif

endmodule

@@ design/pol_cell.sv @@
module pol_cell
    import pol_pkg::*;
#(
    parameter int                 IDX_W = 6,
    parameter logic [IDX_W-1:0]   INDEX = '0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]  pos,
    input  logic [KEY_W-1:0]  left,
    input  logic [KEY_W-1:0]  right,
    output logic [KEY_W-1:0]  entry,
    output logic [KEY_W-1:0]  tap
);

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    logic [KEY_W-1:0] tap_reg;
    logic [KEY_W-1:0] tap_next;

    // insert moves cells behind the point toward the tail, remove pulls them toward the head
    always_comb
    begin
        entry_next = entry_reg;
        tap_next   = tap_reg;
        case (ctrl.op)
            OP_INS:
            begin
                if (INDEX == pos)
                begin
                    entry_next = ctrl.key;
                end
                else if (INDEX > pos)
                begin
                    entry_next = left;
                end
            end
            OP_REM:
            begin
                tap_next = (INDEX == pos) ? entry_reg : '0;
                if (INDEX >= pos)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
    end

    assign entry = entry_reg;
    assign tap   = tap_reg;

endmodule
